// ----- src/cau_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types, operation codes and a width helper for the complex ALU.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int WORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF = 8;
  localparam int FUNC_BITS     = 3;

  typedef enum logic [FUNC_BITS-1:0] {
    FN_ADD  = 3'd0,
    FN_SUB  = 3'd1,
    FN_MUL  = 3'd2,
    FN_DIV  = 3'd3,
    FN_DIST = 3'd4
  } cau_func_t;

  // control group that rides along with every request
  typedef struct packed {
    logic [FUNC_BITS-1:0] func;
    logic                 neg_r;
    logic                 neg_i;
    logic                 dsat_r;   // quotient certainly out of range
    logic                 dsat_i;
    logic                 dz;       // divide with zero divisor
  } cau_ctrl_t;

  // width of the division remainder: holds n << frac and d << (word + 1)
  function automatic int cau_rem_bits(input int w, input int f);
    int a;
    int b;
    a = 2 * w + 2 + f;
    b = 3 * w + 2;
    return (a > b) ? a : b;
  endfunction

endpackage
`default_nettype wire

// ----- src/cau_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cau_req_if / cau_res_if
// Valid/ready channels for operand requests and results.
// ----------------------------------------------------------------------------
interface cau_req_if #(
  parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF
);
  import cau_pkg::*;
  logic                        valid;
  logic                        ready;
  logic [FUNC_BITS-1:0]        func;
  logic signed [WORD_BITS-1:0] a_real;
  logic signed [WORD_BITS-1:0] a_imag;
  logic signed [WORD_BITS-1:0] b_real;
  logic signed [WORD_BITS-1:0] b_imag;

  modport source (output valid, func, a_real, a_imag, b_real, b_imag, input ready);
  modport sink   (input valid, func, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface cau_res_if #(
  parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] res_real;
  logic signed [WORD_BITS-1:0] res_imag;
  logic                        overflow;
  logic                        div_zero;

  modport source (output valid, res_real, res_imag, overflow, div_zero, input ready);
  modport sink   (input valid, res_real, res_imag, overflow, div_zero, output ready);
endinterface
`default_nettype wire

// ----- src/cau_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cau_front
// Four-stage front end: sums and differences, products, signed magnitudes,
// divisor and radicand, then the scaled dividend and range precheck.
// ----------------------------------------------------------------------------
module cau_front #(
  parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  cau_req_if.sink                  req,
  output logic                     out_valid,
  input  logic                     out_ready,
  output cau_pkg::cau_ctrl_t       out_ctrl,
  output logic [2*WORD_BITS:0]     out_mag_r,
  output logic [2*WORD_BITS:0]     out_mag_i,
  output logic [cau_pkg::cau_rem_bits(WORD_BITS, FRAC_BITS)-1:0] out_rem_r,
  output logic [cau_pkg::cau_rem_bits(WORD_BITS, FRAC_BITS)-1:0] out_rem_i,
  output logic [2*WORD_BITS:0]     out_d,
  output logic [2*WORD_BITS+1:0]   out_rad
);
  import cau_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int RW = cau_rem_bits(WORD_BITS, FRAC_BITS);

  logic v1, v2, v3, v4;
  logic r1, r2, r3, r4;

  assign r4        = !v4 || out_ready;
  assign r3        = !v3 || r4;
  assign r2        = !v2 || r3;
  assign r1        = !v1 || r2;
  assign req.ready = r1;
  assign out_valid = v4;

  // stage 1 --------------------------------------------------------------
  logic [FUNC_BITS-1:0] f1;
  logic signed [W-1:0]  ar1, ai1, br1, bi1;
  logic signed [W:0]    sr1, si1;
  logic [W-1:0]         adr1, adi1;

  logic signed [W:0]    dr_c, di_c, sr_c, si_c;
  logic [W-1:0]         adr_c, adi_c;

  always_comb begin
    dr_c  = {req.a_real[W-1], req.a_real} - {req.b_real[W-1], req.b_real};
    di_c  = {req.a_imag[W-1], req.a_imag} - {req.b_imag[W-1], req.b_imag};
    if (req.func == FN_SUB) begin
      sr_c = dr_c;
      si_c = di_c;
    end else begin
      sr_c = {req.a_real[W-1], req.a_real} + {req.b_real[W-1], req.b_real};
      si_c = {req.a_imag[W-1], req.a_imag} + {req.b_imag[W-1], req.b_imag};
    end
    adr_c = dr_c[W] ? W'(-dr_c) : dr_c[W-1:0];
    adi_c = di_c[W] ? W'(-di_c) : di_c[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (r1) begin
      v1 <= req.valid;
    end
    if (r1 && req.valid) begin
      f1   <= req.func;
      ar1  <= req.a_real;
      ai1  <= req.a_imag;
      br1  <= req.b_real;
      bi1  <= req.b_imag;
      sr1  <= sr_c;
      si1  <= si_c;
      adr1 <= adr_c;
      adi1 <= adi_c;
    end
  end

  // stage 2: products ----------------------------------------------------
  logic [FUNC_BITS-1:0]  f2;
  logic signed [W:0]     sr2, si2;
  logic signed [2*W-1:0] prr2, pii2, pri2, pir2, sqbr2, sqbi2;
  logic [2*W-1:0]        sqdr2, sqdi2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (r2) begin
      v2 <= v1;
    end
    if (r2 && v1) begin
      f2    <= f1;
      sr2   <= sr1;
      si2   <= si1;
      prr2  <= ar1 * br1;
      pii2  <= ai1 * bi1;
      pri2  <= ar1 * bi1;
      pir2  <= ai1 * br1;
      sqbr2 <= br1 * br1;
      sqbi2 <= bi1 * bi1;
      sqdr2 <= adr1 * adr1;
      sqdi2 <= adi1 * adi1;
    end
  end

  // stage 3: signed sums to sign and magnitude ---------------------------
  logic [FUNC_BITS-1:0] f3;
  logic                 nr3, ni3, dz3;
  logic [2*W:0]         mr3, mi3, d3, s3;

  logic signed [2*W:0]  xr_c, xi_c;
  logic [2*W:0]         d_c;

  always_comb begin
    xr_c = '0;
    xi_c = '0;
    case (f2)
      FN_ADD, FN_SUB: begin
        xr_c = (2*W+1)'(sr2);
        xi_c = (2*W+1)'(si2);
      end
      FN_MUL: begin
        xr_c = (2*W+1)'(prr2) - (2*W+1)'(pii2);
        xi_c = (2*W+1)'(pri2) + (2*W+1)'(pir2);
      end
      FN_DIV: begin
        xr_c = (2*W+1)'(prr2) + (2*W+1)'(pii2);
        xi_c = (2*W+1)'(pir2) - (2*W+1)'(pri2);
      end
      default: begin
        xr_c = '0;
        xi_c = '0;
      end
    endcase
    d_c = (2*W+1)'($unsigned(sqbr2)) + (2*W+1)'($unsigned(sqbi2));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (r3) begin
      v3 <= v2;
    end
    if (r3 && v2) begin
      f3  <= f2;
      nr3 <= xr_c[2*W];
      ni3 <= xi_c[2*W];
      mr3 <= xr_c[2*W] ? $unsigned(-xr_c) : $unsigned(xr_c);
      mi3 <= xi_c[2*W] ? $unsigned(-xi_c) : $unsigned(xi_c);
      d3  <= d_c;
      s3  <= (2*W+1)'(sqdr2) + (2*W+1)'(sqdi2);
      dz3 <= (f2 == FN_DIV) && (d_c == '0);
    end
  end

  // stage 4: scaled dividend and out-of-range precheck -------------------
  logic [RW-1:0] nr_c, ni_c, dlim_c;

  always_comb begin
    nr_c   = RW'(mr3) << F;
    ni_c   = RW'(mi3) << F;
    dlim_c = RW'(d3) << (W + 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (r4) begin
      v4 <= v3;
    end
    if (r4 && v3) begin
      out_ctrl.func   <= f3;
      out_ctrl.neg_r  <= nr3;
      out_ctrl.neg_i  <= ni3;
      out_ctrl.dsat_r <= nr_c >= dlim_c;
      out_ctrl.dsat_i <= ni_c >= dlim_c;
      out_ctrl.dz     <= dz3;
      out_mag_r       <= mr3;
      out_mag_i       <= mi3;
      out_rem_r       <= nr_c;
      out_rem_i       <= ni_c;
      out_d           <= d3;
      out_rad         <= {1'b0, s3};
    end
  end

endmodule
`default_nettype wire

// ----- src/cau_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cau_cell
// One cell of the chain: one restoring quotient bit for each of the real
// and imaginary quotients and one root bit of the distance square root.
// ----------------------------------------------------------------------------
module cau_cell #(
  parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF,
  parameter int SHIFT     = 0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  cau_pkg::cau_ctrl_t       in_ctrl,
  input  logic [2*WORD_BITS:0]     in_mag_r,
  input  logic [2*WORD_BITS:0]     in_mag_i,
  input  logic [cau_pkg::cau_rem_bits(WORD_BITS, FRAC_BITS)-1:0] in_rem_r,
  input  logic [cau_pkg::cau_rem_bits(WORD_BITS, FRAC_BITS)-1:0] in_rem_i,
  input  logic [2*WORD_BITS:0]     in_d,
  input  logic [2*WORD_BITS+1:0]   in_rad,
  input  logic [WORD_BITS:0]       in_q_r,
  input  logic [WORD_BITS:0]       in_q_i,
  input  logic [WORD_BITS:0]       in_root,
  input  logic [WORD_BITS+3:0]     in_sq_rem,
  output logic                     out_valid,
  input  logic                     out_ready,
  output cau_pkg::cau_ctrl_t       out_ctrl,
  output logic [2*WORD_BITS:0]     out_mag_r,
  output logic [2*WORD_BITS:0]     out_mag_i,
  output logic [cau_pkg::cau_rem_bits(WORD_BITS, FRAC_BITS)-1:0] out_rem_r,
  output logic [cau_pkg::cau_rem_bits(WORD_BITS, FRAC_BITS)-1:0] out_rem_i,
  output logic [2*WORD_BITS:0]     out_d,
  output logic [2*WORD_BITS+1:0]   out_rad,
  output logic [WORD_BITS:0]       out_q_r,
  output logic [WORD_BITS:0]       out_q_i,
  output logic [WORD_BITS:0]       out_root,
  output logic [WORD_BITS+3:0]     out_sq_rem
);
  import cau_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int RW = cau_rem_bits(WORD_BITS, FRAC_BITS);

  logic [RW-1:0]  dsh;
  logic           ge_r, ge_i, ge_s;
  logic [RW-1:0]  rem_r_next, rem_i_next;
  logic [W+3:0]   rem_t, trial, sq_rem_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    dsh        = RW'(in_d) << SHIFT;
    ge_r       = in_rem_r >= dsh;
    ge_i       = in_rem_i >= dsh;
    rem_r_next = ge_r ? in_rem_r - dsh : in_rem_r;
    rem_i_next = ge_i ? in_rem_i - dsh : in_rem_i;
    // next radicand pair comes in under the partial remainder
    rem_t       = {in_sq_rem[W+1:0], in_rad[2*W+1:2*W]};
    trial       = (W+4)'({in_root, 2'b01});
    ge_s        = rem_t >= trial;
    sq_rem_next = ge_s ? rem_t - trial : rem_t;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_ctrl   <= in_ctrl;
      out_mag_r  <= in_mag_r;
      out_mag_i  <= in_mag_i;
      out_rem_r  <= rem_r_next;
      out_rem_i  <= rem_i_next;
      out_d      <= in_d;
      out_rad    <= {in_rad[2*W-1:0], 2'b00};
      out_q_r    <= {in_q_r[W-1:0], ge_r};
      out_q_i    <= {in_q_i[W-1:0], ge_i};
      out_root   <= {in_root[W-1:0], ge_s};
      out_sq_rem <= sq_rem_next;
    end
  end

endmodule
`default_nettype wire

// ----- src/cau_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cau_back
// Result selection, saturation to the word range and the output register.
// ----------------------------------------------------------------------------
module cau_back #(
  parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  cau_pkg::cau_ctrl_t   in_ctrl,
  input  logic [2*WORD_BITS:0] in_mag_r,
  input  logic [2*WORD_BITS:0] in_mag_i,
  input  logic [WORD_BITS:0]   in_q_r,
  input  logic [WORD_BITS:0]   in_q_i,
  input  logic [WORD_BITS:0]   in_root,
  cau_res_if.source            res
);
  import cau_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int PW = 2 * W + 2;

  // returns {saturated, word}
  function automatic logic [W:0] pack_part(input logic neg, input logic [PW-1:0] mag);
    logic [PW-1:0] lim;
    logic [PW-1:0] m;
    logic          o;
    lim = neg ? (PW'(1) << (W - 1)) : ((PW'(1) << (W - 1)) - PW'(1));
    o   = mag > lim;
    m   = o ? lim : mag;
    return {o, (neg ? -m[W-1:0] : m[W-1:0])};
  endfunction

  logic [PW-1:0] mr, mi;
  logic          nr, ni;
  logic [W:0]    pr, pi;
  logic [W-1:0]  rr_next, ri_next;
  logic          ovf_next;

  assign in_ready = !res.valid || res.ready;

  always_comb begin
    mr = '0;
    mi = '0;
    nr = in_ctrl.neg_r;
    ni = in_ctrl.neg_i;
    case (in_ctrl.func)
      FN_ADD, FN_SUB: begin
        mr = PW'(in_mag_r);
        mi = PW'(in_mag_i);
      end
      FN_MUL: begin
        mr = PW'(in_mag_r >> F);
        mi = PW'(in_mag_i >> F);
      end
      FN_DIV: begin
        mr = in_ctrl.dsat_r ? (PW'(1) << W) : PW'(in_q_r);
        mi = in_ctrl.dsat_i ? (PW'(1) << W) : PW'(in_q_i);
      end
      FN_DIST: begin
        mr = PW'(in_root);
        nr = 1'b0;
        ni = 1'b0;
      end
      default: begin
        mr = '0;
        mi = '0;
      end
    endcase
    pr = pack_part(nr, mr);
    pi = pack_part(ni, mi);
    if (in_ctrl.dz) begin
      rr_next  = '0;
      ri_next  = '0;
      ovf_next = 1'b0;
    end else begin
      rr_next  = pr[W-1:0];
      ri_next  = pi[W-1:0];
      ovf_next = pr[W] | pi[W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (in_ready) begin
      res.valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      res.res_real <= rr_next;
      res.res_imag <= ri_next;
      res.overflow <= ovf_next;
      res.div_zero <= in_ctrl.dz;
    end
  end

endmodule
`default_nettype wire

// ----- src/complex_arithmetic_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Complex add, subtract, multiply, divide and distance in signed fixed point.
//
// Requests arrive on req (func plus two complex operands), results leave on
// res (real, imaginary, overflow, div_zero), both valid/ready channels.
// Every request gives exactly one result, in request order.
// Stages: four front stages (sums, products, magnitudes, scaled dividend),
//   WORD_BITS + 1 cells, each resolving one quotient bit of both parts and
//   one root bit of the distance, then the saturating output register.
// Throughput: one request per cycle unless res stalls; every stage is a
//   register with its own valid, so a new request is taken in each cycle.
// When res is stalled the result holds in the output register and the
//   chain keeps filling empty stages; req.ready falls only once every
//   stage holds a request.
// Reset (rst, synchronous) empties all stages; nothing else is kept.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit #(
  parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  cau_req_if.sink   req,
  cau_res_if.source res
);
  import cau_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int RW = cau_rem_bits(WORD_BITS, FRAC_BITS);
  localparam int N  = WORD_BITS + 1;

  logic            c_v     [0:N];
  logic            c_rdy   [0:N];
  cau_ctrl_t       c_ctrl  [0:N];
  logic [2*W:0]    c_mr    [0:N];
  logic [2*W:0]    c_mi    [0:N];
  logic [RW-1:0]   c_rr    [0:N];
  logic [RW-1:0]   c_ri    [0:N];
  logic [2*W:0]    c_d     [0:N];
  logic [2*W+1:0]  c_rad   [0:N];
  logic [W:0]      c_qr    [0:N];
  logic [W:0]      c_qi    [0:N];
  logic [W:0]      c_root  [0:N];
  logic [W+3:0]    c_srem  [0:N];

  assign c_qr[0]   = '0;
  assign c_qi[0]   = '0;
  assign c_root[0] = '0;
  assign c_srem[0] = '0;

  cau_front #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .out_valid (c_v[0]),
    .out_ready (c_rdy[0]),
    .out_ctrl  (c_ctrl[0]),
    .out_mag_r (c_mr[0]),
    .out_mag_i (c_mi[0]),
    .out_rem_r (c_rr[0]),
    .out_rem_i (c_ri[0]),
    .out_d     (c_d[0]),
    .out_rad   (c_rad[0])
  );

  for (genvar i = 0; i < N; i++) begin : g_cell
    cau_cell #(
      .WORD_BITS (WORD_BITS),
      .FRAC_BITS (FRAC_BITS),
      .SHIFT     (W - i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .in_valid   (c_v[i]),
      .in_ready   (c_rdy[i]),
      .in_ctrl    (c_ctrl[i]),
      .in_mag_r   (c_mr[i]),
      .in_mag_i   (c_mi[i]),
      .in_rem_r   (c_rr[i]),
      .in_rem_i   (c_ri[i]),
      .in_d       (c_d[i]),
      .in_rad     (c_rad[i]),
      .in_q_r     (c_qr[i]),
      .in_q_i     (c_qi[i]),
      .in_root    (c_root[i]),
      .in_sq_rem  (c_srem[i]),
      .out_valid  (c_v[i+1]),
      .out_ready  (c_rdy[i+1]),
      .out_ctrl   (c_ctrl[i+1]),
      .out_mag_r  (c_mr[i+1]),
      .out_mag_i  (c_mi[i+1]),
      .out_rem_r  (c_rr[i+1]),
      .out_rem_i  (c_ri[i+1]),
      .out_d      (c_d[i+1]),
      .out_rad    (c_rad[i+1]),
      .out_q_r    (c_qr[i+1]),
      .out_q_i    (c_qi[i+1]),
      .out_root   (c_root[i+1]),
      .out_sq_rem (c_srem[i+1])
    );
  end

  cau_back #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (c_v[N]),
    .in_ready (c_rdy[N]),
    .in_ctrl  (c_ctrl[N]),
    .in_mag_r (c_mr[N]),
    .in_mag_i (c_mi[N]),
    .in_q_r   (c_qr[N]),
    .in_q_i   (c_qi[N]),
    .in_root  (c_root[N]),
    .res      (res)
  );

  // an empty output register means every stage can move
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !res.valid |-> req.ready)
    else $error("request side stalled with empty output");

  a_div_zero_result: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.div_zero |-> !res.overflow && res.res_real == '0 && res.res_imag == '0)
    else $error("zero-divisor result not cleared");

  a_dz_only_on_div: assert property (@(posedge clk) disable iff (rst)
    c_v[N] && c_ctrl[N].dz |-> c_ctrl[N].func == FN_DIV)
    else $error("divide-by-zero mark on a non-divide request");

endmodule
`default_nettype wire
